@@ sv/stwci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwci_pkg
// Shared types, codes, limits and helper functions of the three-mode timer.
// ----------------------------------------------------------------------------
package stwci_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 12;

  // workout setting limits
  localparam logic [6:0]  SETS_MIN     = 7'd1;
  localparam logic [6:0]  SETS_MAX     = 7'd99;
  localparam logic [11:0] WORK_MIN_SEC = 12'd5;
  localparam logic [11:0] WORK_MAX_SEC = 12'd3600;
  localparam logic [11:0] REST_MAX_SEC = 12'd3600;

  // countdown and stopwatch constants
  localparam logic [10:0] STEP_SEC       = 11'd30;
  localparam logic [10:0] CD_MAX_SEC     = 11'd1800;
  localparam logic [10:0] CD_DEFAULT_SEC = 11'd30;
  localparam logic [22:0] SW_MAX_MS      = 23'd5999990;
  localparam logic [22:0] WARN_MS        = 23'd10000;
  localparam logic [9:0]  MS_PER_SEC     = 10'd1000;

  // floor(x / 30) for x up to 1815: (x * 2185) >> 16
  localparam logic [23:0] SNAP_RECIP = 24'd2185;

  // register values after reset
  localparam logic [10:0] RST_INIT_SEC = 11'd30;
  localparam logic [6:0]  RST_SETS     = 7'd5;
  localparam logic [11:0] RST_WORK_SEC = 12'd120;
  localparam logic [11:0] RST_REST_SEC = 12'd30;

  typedef enum logic [3:0] {
    OP_TICK          = 4'd0,
    OP_TOGGLE        = 4'd1,
    OP_PAUSE         = 4'd2,
    OP_PLUS          = 4'd3,
    OP_RESET         = 4'd4,
    OP_SESSION_RESET = 4'd5,
    OP_CYCLE         = 4'd6,
    OP_WORKOUT_ON    = 4'd7,
    OP_WORKOUT_OFF   = 4'd8,
    OP_LOAD          = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    REG_CD_INIT     = 3'd0,
    REG_SETS        = 3'd1,
    REG_WORK        = 3'd2,
    REG_REST        = 3'd3,
    REG_READY       = 3'd4,
    REG_START_WO    = 3'd5,
    REG_START_CD    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    M_SW = 2'd0,
    M_CD = 2'd1,
    M_WO = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_PAUSE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] load_seconds;
  } event_t;

  typedef struct packed {
    mode_t       mode;
    phase_t      phase;
    logic [22:0] readout_ms;
    logic [10:0] cd_len_sec;
    logic        warn_near_end;
    logic [6:0]  cur_set;
    logic        on_rest;
  } snap_t;

  // saturate to 30:00, then round to the nearest 30 s step, halves up
  function automatic logic [10:0] snap_sec(input logic [10:0] sec);
    logic [11:0] rnd;
    logic [23:0] prod;
    logic [5:0]  q;
    rnd  = {1'b0, sec} + 12'(STEP_SEC >> 1);
    prod = 24'(rnd) * SNAP_RECIP;
    q    = prod[21:16];
    if (sec > CD_MAX_SEC) begin
      snap_sec = CD_MAX_SEC;
    end else begin
      snap_sec = 11'(q) * STEP_SEC;
    end
  endfunction

  function automatic logic [22:0] ms_of(input logic [11:0] sec);
    ms_of = 23'(sec) * 23'(MS_PER_SEC);
  endfunction

endpackage

@@ sv/stwci_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwci_core
// Settings registers, per-mode timer state and the event logic. Produces the
// snapshot that follows the event being applied in this cycle.
// ----------------------------------------------------------------------------
module stwci_core
  import stwci_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    ev_go,
  input  event_t  ev,
  output snap_t   snap
);

  // settings
  logic [10:0] init_r, init_nxt;
  logic [6:0]  sets_r, sets_nxt;
  logic [11:0] work_r, work_nxt;
  logic [11:0] rest_r, rest_nxt;
  logic        ready_r, ready_nxt;
  logic        siw_r, siw_nxt;
  logic        ssc_r, ssc_nxt;
  logic        cfg_start;
  logic        cfg_wo_idle;

  // timer state
  mode_t       mode_r, mode_nxt;
  logic        simple_r, simple_nxt;
  logic [10:0] dur_r, dur_nxt;
  logic [6:0]  set_r, set_nxt;
  logic        rest_leg_r, rest_leg_nxt;
  phase_t      phase_r [3];
  phase_t      phase_nxt [3];
  logic [22:0] value_r [3];
  logic [22:0] value_nxt [3];
  logic [31:0] mark_r [3];
  logic [31:0] mark_nxt [3];
  logic [2:0]  mvalid_r, mvalid_nxt;

  // event helpers
  logic        do_pause;
  logic        do_wo_idle;
  logic        do_cd_load;
  logic        do_run;
  phase_t      cur_phase;
  logic [22:0] cur_val;
  logic [31:0] dt;
  logic [22:0] sw_room;
  logic [22:0] work_ms;
  logic [22:0] rest_ms;
  logic [10:0] cfg_dur;
  logic [10:0] load_dur;
  logic [10:0] plus_dur;
  logic [10:0] load_sat;

  always_comb begin
    init_nxt    = init_r;
    sets_nxt    = sets_r;
    work_nxt    = work_r;
    rest_nxt    = rest_r;
    ready_nxt   = ready_r;
    siw_nxt     = siw_r;
    ssc_nxt     = ssc_r;
    cfg_start   = 1'b0;
    cfg_wo_idle = 1'b0;
    if (cfg.we) begin
      case (cfg_idx_t'(cfg.index))
        REG_CD_INIT: begin
          init_nxt  = cfg.data[10:0];
          cfg_start = 1'b1;
        end
        REG_SETS: begin
          if (cfg.data[6:0] < SETS_MIN) begin
            sets_nxt = SETS_MIN;
          end else if (cfg.data[6:0] > SETS_MAX) begin
            sets_nxt = SETS_MAX;
          end else begin
            sets_nxt = cfg.data[6:0];
          end
          cfg_wo_idle = 1'b1;
        end
        REG_WORK: begin
          if (cfg.data < WORK_MIN_SEC) begin
            work_nxt = WORK_MIN_SEC;
          end else if (cfg.data > WORK_MAX_SEC) begin
            work_nxt = WORK_MAX_SEC;
          end else begin
            work_nxt = cfg.data;
          end
          cfg_wo_idle = 1'b1;
        end
        REG_REST: begin
          rest_nxt    = (cfg.data > REST_MAX_SEC) ? REST_MAX_SEC : cfg.data;
          cfg_wo_idle = 1'b1;
        end
        REG_READY: begin
          ready_nxt = cfg.data[0];
        end
        REG_START_WO: begin
          siw_nxt   = cfg.data[0];
          cfg_start = 1'b1;
        end
        REG_START_CD: begin
          ssc_nxt   = cfg.data[0];
          cfg_start = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_phase = phase_r[mode_r];
  assign cur_val   = value_r[mode_r];
  assign dt        = ev.now_ms - mark_r[mode_r];
  assign sw_room   = SW_MAX_MS - cur_val;
  assign work_ms   = ms_of(work_nxt);
  assign rest_ms   = ms_of(rest_r);
  assign cfg_dur   = snap_sec((init_nxt == 11'd0) ? CD_DEFAULT_SEC : init_nxt);
  assign load_sat  = (ev.load_seconds > 16'(CD_MAX_SEC)) ? CD_MAX_SEC
                                                          : ev.load_seconds[10:0];
  assign load_dur  = snap_sec(load_sat);
  assign plus_dur  = (dur_r >= CD_MAX_SEC - STEP_SEC) ? CD_MAX_SEC : dur_r + STEP_SEC;

  always_comb begin
    mode_nxt     = mode_r;
    simple_nxt   = simple_r;
    dur_nxt      = dur_r;
    set_nxt      = set_r;
    rest_leg_nxt = rest_leg_r;
    phase_nxt    = phase_r;
    value_nxt    = value_r;
    mark_nxt     = mark_r;
    mvalid_nxt   = mvalid_r;
    do_pause     = 1'b0;
    do_wo_idle   = 1'b0;
    do_cd_load   = 1'b0;
    do_run       = 1'b0;

    if (cfg_start) begin
      simple_nxt       = ssc_nxt;
      phase_nxt[M_SW]  = PH_IDLE;
      value_nxt[M_SW]  = '0;
      mvalid_nxt[M_SW] = 1'b0;
      dur_nxt          = cfg_dur;
      do_cd_load       = 1'b1;
      do_wo_idle       = 1'b1;
      mode_nxt         = siw_nxt ? M_WO : (ssc_nxt ? M_CD : M_SW);
    end else if (cfg_wo_idle) begin
      do_wo_idle = 1'b1;
    end else if (ev_go) begin
      case (opcode_t'(ev.opcode))
        OP_TICK: begin
          if (cur_phase == PH_RUN) begin
            mark_nxt[mode_r] = ev.now_ms;
            if (!mvalid_r[mode_r]) begin
              // first tick after a start or a new leg only takes the mark
              mvalid_nxt[mode_r] = 1'b1;
            end else if (mode_r == M_SW) begin
              if (cur_val < SW_MAX_MS) begin
                value_nxt[M_SW] = cur_val + ((dt < 32'(sw_room)) ? dt[22:0] : sw_room);
              end
            end else if (dt >= 32'(cur_val)) begin
              value_nxt[mode_r]  = '0;
              mvalid_nxt[mode_r] = 1'b0;
              if (mode_r == M_WO) begin
                // leg over: next leg, or the session ends
                if (rest_leg_r) begin
                  if (set_r < sets_r) begin
                    set_nxt = set_r + 7'd1;
                  end
                  rest_leg_nxt    = 1'b0;
                  value_nxt[M_WO] = work_ms;
                  phase_nxt[M_WO] = PH_RUN;
                end else if (set_r >= sets_r) begin
                  rest_leg_nxt    = 1'b0;
                  phase_nxt[M_WO] = PH_DONE;
                end else if (rest_r == 12'd0) begin
                  set_nxt         = set_r + 7'd1;
                  value_nxt[M_WO] = work_ms;
                  phase_nxt[M_WO] = PH_RUN;
                end else begin
                  rest_leg_nxt    = 1'b1;
                  value_nxt[M_WO] = rest_ms;
                  phase_nxt[M_WO] = PH_RUN;
                end
              end else begin
                phase_nxt[mode_r] = PH_DONE;
              end
            end else begin
              value_nxt[mode_r] = cur_val - dt[22:0];
            end
          end
        end
        OP_TOGGLE: begin
          if (mode_r == M_WO && !ready_r) begin
            // workout locked
          end else if (mode_r == M_CD && cur_phase == PH_DONE) begin
            if (dur_r != 11'd0) begin
              do_cd_load = 1'b1;
              do_run     = 1'b1;
            end
          end else if (mode_r == M_WO && cur_phase == PH_DONE) begin
            do_wo_idle = 1'b1;
            do_run     = 1'b1;
          end else if (cur_phase == PH_RUN) begin
            do_pause = 1'b1;
          end else if (mode_r == M_CD) begin
            if (dur_r != 11'd0) begin
              do_cd_load = (cur_phase == PH_IDLE) && (cur_val == 23'd0);
              do_run     = 1'b1;
            end
          end else if (mode_r == M_WO) begin
            do_wo_idle = (cur_phase == PH_IDLE) && (cur_val == 23'd0);
            do_run     = 1'b1;
          end else begin
            do_run = 1'b1;
          end
        end
        OP_PAUSE: begin
          do_pause = 1'b1;
        end
        OP_PLUS: begin
          if (mode_r != M_WO && cur_phase != PH_RUN) begin
            if (mode_r == M_SW) begin
              phase_nxt[M_SW]  = PH_IDLE;
              value_nxt[M_SW]  = '0;
              mvalid_nxt[M_SW] = 1'b0;
            end else begin
              dur_nxt    = plus_dur;
              do_cd_load = 1'b1;
            end
          end
        end
        OP_RESET, OP_SESSION_RESET: begin
          if (cur_phase != PH_RUN) begin
            if (mode_r == M_WO) begin
              do_wo_idle = 1'b1;
            end else if (mode_r == M_SW) begin
              phase_nxt[M_SW]  = PH_IDLE;
              value_nxt[M_SW]  = '0;
              mvalid_nxt[M_SW] = 1'b0;
            end else begin
              dur_nxt    = '0;
              do_cd_load = 1'b1;
            end
          end
        end
        OP_CYCLE: begin
          do_pause = 1'b1;
          if (mode_r == M_SW) begin
            simple_nxt = 1'b1;
            mode_nxt   = M_CD;
          end else if (mode_r == M_CD) begin
            simple_nxt = 1'b1;
            mode_nxt   = M_WO;
            do_wo_idle = 1'b1;
          end else begin
            simple_nxt = 1'b0;
            mode_nxt   = M_SW;
          end
        end
        OP_WORKOUT_ON: begin
          do_pause   = 1'b1;
          mode_nxt   = M_WO;
          do_wo_idle = 1'b1;
        end
        OP_WORKOUT_OFF: begin
          do_pause = 1'b1;
          mode_nxt = simple_r ? M_CD : M_SW;
        end
        OP_LOAD: begin
          dur_nxt    = load_dur;
          do_cd_load = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // shared actions, applied in a fixed order
    if (do_pause && cur_phase == PH_RUN) begin
      phase_nxt[mode_r]  = PH_PAUSE;
      mvalid_nxt[mode_r] = 1'b0;
    end
    if (do_wo_idle) begin
      set_nxt          = 7'd1;
      rest_leg_nxt     = 1'b0;
      phase_nxt[M_WO]  = PH_IDLE;
      value_nxt[M_WO]  = work_ms;
      mvalid_nxt[M_WO] = 1'b0;
    end
    if (do_cd_load) begin
      phase_nxt[M_CD]  = PH_IDLE;
      value_nxt[M_CD]  = ms_of({1'b0, dur_nxt});
      mvalid_nxt[M_CD] = 1'b0;
    end
    if (do_run) begin
      phase_nxt[mode_r]  = PH_RUN;
      mvalid_nxt[mode_r] = 1'b0;
    end
  end

  // snapshot of the mode active after the event
  always_comb begin
    snap.mode          = mode_nxt;
    snap.phase         = phase_nxt[mode_nxt];
    snap.readout_ms    = value_nxt[mode_nxt];
    snap.cd_len_sec    = dur_nxt;
    snap.warn_near_end = (mode_nxt != M_SW) && (phase_nxt[mode_nxt] == PH_RUN) &&
                         (value_nxt[mode_nxt] <= WARN_MS);
    snap.cur_set       = set_nxt;
    snap.on_rest       = rest_leg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r        <= RST_INIT_SEC;
      sets_r        <= RST_SETS;
      work_r        <= RST_WORK_SEC;
      rest_r        <= RST_REST_SEC;
      ready_r       <= 1'b0;
      siw_r         <= 1'b0;
      ssc_r         <= 1'b0;
      mode_r        <= M_SW;
      simple_r      <= 1'b0;
      dur_r         <= snap_sec(RST_INIT_SEC);
      set_r         <= 7'd1;
      rest_leg_r    <= 1'b0;
      phase_r[M_SW] <= PH_IDLE;
      phase_r[M_CD] <= PH_IDLE;
      phase_r[M_WO] <= PH_IDLE;
      value_r[M_SW] <= '0;
      value_r[M_CD] <= ms_of({1'b0, snap_sec(RST_INIT_SEC)});
      value_r[M_WO] <= ms_of(RST_WORK_SEC);
      mvalid_r      <= '0;
    end else begin
      init_r     <= init_nxt;
      sets_r     <= sets_nxt;
      work_r     <= work_nxt;
      rest_r     <= rest_nxt;
      ready_r    <= ready_nxt;
      siw_r      <= siw_nxt;
      ssc_r      <= ssc_nxt;
      mode_r     <= mode_nxt;
      simple_r   <= simple_nxt;
      dur_r      <= dur_nxt;
      set_r      <= set_nxt;
      rest_leg_r <= rest_leg_nxt;
      phase_r    <= phase_nxt;
      value_r    <= value_nxt;
      mvalid_r   <= mvalid_nxt;
    end
  end

  // tick marks are only read while their valid bit is set
  always_ff @(posedge clk) begin
    mark_r <= mark_nxt;
  end

  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    set_r >= SETS_MIN && set_r <= sets_r)
    else $error("workout set number out of range");

  a_dur_limit: assert property (@(posedge clk) disable iff (!rst_n)
    dur_r <= CD_MAX_SEC)
    else $error("countdown duration above limit");

  a_wo_settings_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.we && (cfg.index == REG_SETS || cfg.index == REG_WORK || cfg.index == REG_REST)
    |=> phase_r[M_WO] == PH_IDLE && set_r == 7'd1 && !rest_leg_r)
    else $error("workout not back at first work leg after settings write");

  a_first_tick_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ev_go && !cfg.we && ev.opcode == OP_TICK && phase_r[mode_r] == PH_RUN &&
    !mvalid_r[mode_r]
    |=> mvalid_r[$past(mode_r)] && mark_r[$past(mode_r)] == $past(ev.now_ms))
    else $error("first tick did not take the mark");

endmodule

@@ sv/stopwatch_countdown_interval_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_countdown_interval_timer
// Three-mode timer (stopwatch, countdown, interval workout) with one
// snapshot per event item.
// ----------------------------------------------------------------------------
// Every event item gives exactly one snapshot item. The block takes one item
// per clock unless the output stalls: an item goes into the input register,
// then passes through the combinational event logic into the snapshot
// register once that register is free, so a stalled output holds at most
// one finished snapshot and one waiting item.
// Settings must be written through the cfg port while no item is in flight;
// the block itself does not enforce this. Writing the countdown start value
// or either start-mode bit restarts all three timers, writing a workout
// setting returns the workout to set one.
module stopwatch_countdown_interval_timer
  import stwci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_opcode,
  input  logic [31:0]          in_now_ms,
  input  logic [15:0]          in_load_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_mode,
  output logic [1:0]           out_phase,
  output logic [22:0]          out_readout_ms,
  output logic [10:0]          out_cd_len_sec,
  output logic                 out_warn_near_end,
  output logic [6:0]           out_cur_set,
  output logic                 out_on_rest,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic    ev_valid_r;
  event_t  ev_r;
  logic    out_valid_r;
  snap_t   out_r;
  logic    go;
  snap_t   snap;
  cfg_wr_t cfg_wr;

  // event moves into the snapshot register when that register is free or being read out
  assign go       = ev_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ev_valid_r || go;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_wdata;

  stwci_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .ev_go (go),
    .ev    (ev_r),
    .snap  (snap)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        ev_valid_r <= in_valid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.opcode       <= in_opcode;
      ev_r.now_ms       <= in_now_ms;
      ev_r.load_seconds <= in_load_seconds;
    end
    if (go) begin
      out_r <= snap;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = out_r.mode;
  assign out_phase         = out_r.phase;
  assign out_readout_ms    = out_r.readout_ms;
  assign out_cd_len_sec    = out_r.cd_len_sec;
  assign out_warn_near_end = out_r.warn_near_end;
  assign out_cur_set       = out_r.cur_set;
  assign out_on_rest       = out_r.on_rest;

endmodule
